@@ rtl/afrg_pkg.sv @@
// afrg_pkg: shared widths, constants and types of the frame rate governor
// no dependencies; used by the channel interfaces, the governor top level and the bench

package afrg_pkg;

   // field widths
   localparam int RATE_W  = 8;
   localparam int DUR_W   = 16;
   localparam int DELAY_W = 10;
   localparam int AVG_W   = 24;
   localparam int CSR_W   = 32;
   localparam int ADDR_W  = 3;

   // serial divide and multiply widths
   localparam int PER_W   = 10;   // 1000 / rate dividend
   localparam int AVGN_W  = 28;   // 9*avg + 256*dur + 5 fits in 28 bits
   localparam int PROD_W  = AVG_W + RATE_W;

   // one second in ms, plain and in q16.8
   localparam logic [PER_W-1:0]  MS_PER_SEC    = PER_W'(1000);
   localparam logic [AVGN_W-1:0] MS_PER_SEC_Q8 = AVGN_W'(256000);

   // average weight: new = (9*avg + 256*dur + 5) / 10
   localparam logic [RATE_W-1:0] EMA_DIVISOR = RATE_W'(10);
   localparam logic [AVGN_W-1:0] EMA_ROUND   = AVGN_W'(5);

   // avg*rate limits: slow above 1.10 periods, fast below 0.85 periods
   localparam logic [PROD_W-1:0] SLOW_LIMIT = PROD_W'(281600);
   localparam logic [PROD_W-1:0] FAST_LIMIT = PROD_W'(217600);

   // reset values of the registers
   localparam int RST_TARGET = 60;
   localparam int RST_MIN    = 30;

   // register index, taken from paddr bit 2
   typedef enum logic {
      REG_TARGET = 1'b0,
      REG_MIN    = 1'b1
   } reg_index_type;

   // governor sequencer
   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_LOAD   = 6'b000010,
      S_DIV    = 6'b000100,
      S_MUL    = 6'b001000,
      S_DONE   = 6'b010000,
      S_RELOAD = 6'b100000
   } gov_state_type;

endpackage

@@ rtl/afrg_req_if.sv @@
// afrg_req_if: input channel carrying one measured frame duration per word
// depends on afrg_pkg for the field width

interface afrg_req_if import afrg_pkg::*; ;
   logic             valid;
   logic             ready;
   logic [DUR_W-1:0] frame_duration;

   modport source (output valid, output frame_duration, input ready);
   modport sink (input valid, input frame_duration, output ready);
endinterface

@@ rtl/afrg_rsp_if.sv @@
// afrg_rsp_if: result channel carrying delay, active rate and change flag
// depends on afrg_pkg for the field widths

interface afrg_rsp_if import afrg_pkg::*; ;
   logic               valid;
   logic               ready;
   logic [DELAY_W-1:0] delay_ms;
   logic [RATE_W-1:0]  active_rate;
   logic               rate_changed;

   modport source (output valid, output delay_ms, output active_rate, output rate_changed,
                   input ready);
   modport sink (input valid, input delay_ms, input active_rate, input rate_changed,
                 output ready);
endinterface

@@ rtl/afrg_div.sv @@
// afrg_div: restoring divider, one quotient bit per cycle, msb first
// standalone; used by the governor for the period, the average and its reload

module afrg_div #(
   parameter int DW = 28,
   parameter int VW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          busy,
   output logic [DW-1:0] quotient
);

   localparam int CNT_W = $clog2(DW + 1);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DW-1:0]    quo_ff, quo_in;
   logic [VW-1:0]    rem_ff, rem_in;
   logic [VW-1:0]    dvs_ff;
   logic [VW:0]      trial;
   logic             fits;

   // one restoring step: bring down the next dividend bit
   always_comb begin
      trial  = {rem_ff, quo_ff[DW-1]};
      fits   = trial >= {1'b0, dvs_ff};
      rem_in = fits ? VW'(trial - {1'b0, dvs_ff}) : trial[VW-1:0];
      quo_in = {quo_ff[DW-2:0], fits};
      cnt_in = cnt_ff - CNT_W'(1);
   end

   // step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= CNT_W'(DW);
      end else if (busy) begin
         cnt_ff <= cnt_in;
      end
   end

   // remainder and dividend/quotient shift register
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign busy     = cnt_ff != '0;
   assign quotient = quo_ff;

endmodule

@@ rtl/afrg_mul.sv @@
// afrg_mul: shift-and-add multiplier, one multiplier bit per cycle, msb first
// standalone; used by the governor to form average times rate

module afrg_mul #(
   parameter int AW = 24,
   parameter int BW = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [AW-1:0]    mcand,
   input  logic [BW-1:0]    mplier,
   output logic             busy,
   output logic [AW+BW-1:0] product
);

   localparam int CNT_W = $clog2(BW + 1);
   localparam int PW    = AW + BW;

   logic [CNT_W-1:0] cnt_ff;
   logic [PW-1:0]    acc_ff, acc_in;
   logic [AW-1:0]    mcand_ff;
   logic [BW-1:0]    mplier_ff;

   // double the partial sum and add the multiplicand where the bit is set
   always_comb begin
      acc_in = {acc_ff[PW-2:0], 1'b0};
      if (mplier_ff[BW-1]) begin
         acc_in = acc_in + PW'(mcand_ff);
      end
   end

   // step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= CNT_W'(BW);
      end else if (busy) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
   end

   // operands and accumulator
   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff    <= '0;
         mcand_ff  <= mcand;
         mplier_ff <= mplier;
      end else if (busy) begin
         acc_ff    <= acc_in;
         mplier_ff <= {mplier_ff[BW-2:0], 1'b0};
      end
   end

   assign busy    = cnt_ff != '0;
   assign product = acc_ff;

endmodule

@@ rtl/adaptive_frame_rate_governor.sv @@
// adaptive_frame_rate_governor: top level, sequencer, state and csr port
// depends on afrg_pkg, afrg_req_if, afrg_rsp_if, afrg_div and afrg_mul
//
// usage
// - req_ch carries one measured frame duration (ms) per word; rsp_ch returns one
//   word per input: the delay to fill out the current frame period (computed
//   from the rate before the update), the active rate after the update and a
//   flag that is set when this update moved the rate
// - the csr port holds target_frame_rate at address 0 and the rate floor at
//   address 4; a target write clamps it to [floor, MAX_RATE], reloads the rate
//   and recomputes the average with a 28-step serial divide; req_ch is not
//   ready while this runs
// - an item passes through a load step, the bit-serial divide of the average
//   by ten (the period divide 1000/rate runs alongside it), the bit-serial
//   average times rate multiply and an update step; the next item is taken
//   only once the block is back in idle, so a new item is not accepted
//   before the last one has been through its update step
// - the result sits in an output register; a stalled receiver holds the
//   update step, and a new item is still accepted while a result waits
// - reset restores target 60 (clamped to MAX_RATE), minimum 30 (capped where it
//   acts) with the matching average; no clearing pass is needed

module adaptive_frame_rate_governor import afrg_pkg::*; #(
   parameter int MAX_RATE = 240
) (
   input  logic              clock,
   input  logic              reset,
   afrg_req_if.sink          req_ch,
   afrg_rsp_if.source        rsp_ch,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [CSR_W-1:0]  pwdata,
   output logic [CSR_W-1:0]  prdata,
   output logic              pready
);

   // reset values, clamped at elaboration
   localparam int RST_MIN_EFF = (RST_MIN > MAX_RATE) ? MAX_RATE : RST_MIN;
   localparam int RST_TGT_LO  = (RST_TARGET < RST_MIN_EFF) ? RST_MIN_EFF : RST_TARGET;
   localparam int RST_TGT     = (RST_TGT_LO > MAX_RATE) ? MAX_RATE : RST_TGT_LO;
   localparam int RST_AVG     = 256000 / RST_TGT;

   localparam logic [RATE_W-1:0] MAX_R = RATE_W'(MAX_RATE);

   gov_state_type state_ff, state_in;

   logic [RATE_W-1:0]  target_ff, target_in;
   logic [RATE_W-1:0]  min_ff, min_in;
   logic [RATE_W-1:0]  rate_ff, rate_in;
   logic [AVG_W-1:0]   avg_ff, avg_in;
   logic [DUR_W-1:0]   dur_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DELAY_W-1:0] delay_ff, delay_in;
   logic [RATE_W-1:0]  out_rate_ff;
   logic               changed_ff, changed_in;

   logic               csr_wr;
   reg_index_type      csr_idx;
   logic [RATE_W-1:0]  wr_val;
   logic [RATE_W-1:0]  min_eff;
   logic [RATE_W-1:0]  tgt_lo;
   logic [RATE_W-1:0]  tgt_clamp;
   logic               tgt_wr;

   logic               req_take;
   logic               out_free;
   logic               gate;
   logic               slow;
   logic               fast;
   logic [RATE_W-1:0]  rate_dn;
   logic [RATE_W:0]    rate_up;
   logic [RATE_W-1:0]  rate_new;

   logic               adiv_start, adiv_busy;
   logic [AVGN_W-1:0]  adiv_num, adiv_quo;
   logic [RATE_W-1:0]  adiv_den;
   logic               qdiv_start, qdiv_busy;
   logic [PER_W-1:0]   qdiv_quo;
   logic               mul_start, mul_busy;
   logic [PROD_W-1:0]  mul_prod;
   logic [AVGN_W-1:0]  ema_num;

   // csr decode and clamping
   always_comb begin
      csr_wr  = psel && penable && pwrite;
      csr_idx = reg_index_type'(paddr[2]);
      wr_val  = pwdata[RATE_W-1:0];
      min_eff = (min_ff == '0) ? RATE_W'(1) : ((min_ff > MAX_R) ? MAX_R : min_ff);
      tgt_lo    = (wr_val < min_eff) ? min_eff : wr_val;
      tgt_clamp = (tgt_lo > MAX_R) ? MAX_R : tgt_lo;
      tgt_wr    = csr_wr && (csr_idx == REG_TARGET);
   end

   assign pready = 1'b1;
   assign prdata = (csr_idx == REG_MIN) ? CSR_W'(min_ff) : CSR_W'(target_ff);

   // handshakes
   assign req_ch.ready = state_ff == S_IDLE;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   // weighted sum for the average: 9*avg + 256*dur + 5
   assign ema_num = (AVGN_W'(avg_ff) << 3) + AVGN_W'(avg_ff)
                    + AVGN_W'({dur_ff, 8'h00}) + EMA_ROUND;

   // divider and multiplier launch
   always_comb begin
      adiv_start = 1'b0;
      adiv_num   = ema_num;
      adiv_den   = EMA_DIVISOR;
      if (tgt_wr) begin
         adiv_start = 1'b1;
         adiv_num   = MS_PER_SEC_Q8;
         adiv_den   = tgt_clamp;
      end else if (state_ff == S_LOAD) begin
         adiv_start = 1'b1;
      end
      qdiv_start = state_ff == S_LOAD;
      mul_start  = (state_ff == S_DIV) && !adiv_busy && !qdiv_busy;
   end

   // rate step decision on the new average
   always_comb begin
      gate    = {1'b0, target_ff} >= ({1'b0, min_eff} + (RATE_W+1)'(2));
      slow    = mul_prod > SLOW_LIMIT;
      fast    = mul_prod < FAST_LIMIT;
      rate_dn = rate_ff - RATE_W'(1);
      rate_up = {1'b0, rate_ff} + (RATE_W+1)'(1);
      if (slow) begin
         rate_new = (rate_dn < min_eff) ? min_eff : rate_dn;
      end else if (fast) begin
         rate_new = (rate_up > {1'b0, target_ff}) ? target_ff : rate_up[RATE_W-1:0];
      end else begin
         rate_new = rate_ff;
      end
   end

   // sequencer and state update
   always_comb begin
      state_in     = state_ff;
      target_in    = target_ff;
      min_in       = min_ff;
      rate_in      = rate_ff;
      avg_in       = avg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      delay_in     = delay_ff;
      changed_in   = changed_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (mul_start) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (!mul_busy) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               delay_in     = ({6'b0, qdiv_quo} > dur_ff)
                              ? DELAY_W'(qdiv_quo - dur_ff[PER_W-1:0]) : '0;
               if (gate) begin
                  avg_in     = adiv_quo[AVG_W-1:0];
                  rate_in    = rate_new;
                  changed_in = rate_new != rate_ff;
               end else begin
                  changed_in = 1'b0;
               end
            end
         end
         S_RELOAD: begin
            if (!adiv_busy) begin
               state_in = S_IDLE;
               avg_in   = adiv_quo[AVG_W-1:0];
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // register writes take priority; a target write restarts the reload
      if (tgt_wr) begin
         target_in = tgt_clamp;
         rate_in   = tgt_clamp;
         state_in  = S_RELOAD;
      end else if (csr_wr && (csr_idx == REG_MIN)) begin
         min_in = wr_val;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         target_ff    <= RATE_W'(RST_TGT);
         min_ff       <= RATE_W'(RST_MIN);
         rate_ff      <= RATE_W'(RST_TGT);
         avg_ff       <= AVG_W'(RST_AVG);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         target_ff    <= target_in;
         min_ff       <= min_in;
         rate_ff      <= rate_in;
         avg_ff       <= avg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         dur_ff <= req_ch.frame_duration;
      end
      delay_ff    <= delay_in;
      changed_ff  <= changed_in;
      if ((state_ff == S_DONE) && out_free) begin
         out_rate_ff <= rate_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.delay_ms     = delay_ff;
   assign rsp_ch.active_rate  = out_rate_ff;
   assign rsp_ch.rate_changed = changed_ff;

   // average divide by ten, shared with the 256000/target reload
   afrg_div #(
      .DW (AVGN_W),
      .VW (RATE_W)
   ) u_avg_div (
      .clock    (clock),
      .reset    (reset),
      .start    (adiv_start),
      .dividend (adiv_num),
      .divisor  (adiv_den),
      .busy     (adiv_busy),
      .quotient (adiv_quo)
   );

   // frame period 1000/rate
   afrg_div #(
      .DW (PER_W),
      .VW (RATE_W)
   ) u_per_div (
      .clock    (clock),
      .reset    (reset),
      .start    (qdiv_start),
      .dividend (MS_PER_SEC),
      .divisor  (rate_ff),
      .busy     (qdiv_busy),
      .quotient (qdiv_quo)
   );

   // new average times current rate
   afrg_mul #(
      .AW (AVG_W),
      .BW (RATE_W)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (adiv_quo[AVG_W-1:0]),
      .mplier  (rate_ff),
      .busy    (mul_busy),
      .product (mul_prod)
   );

   // rate never leaves [1, MAX_RATE]
   a_rate_range: assert property (@(posedge clock) disable iff (reset)
      (rate_ff != '0) && (rate_ff <= MAX_R))
      else $error("active rate out of range");

   // arithmetic units are quiet whenever a new word may be taken
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (!adiv_busy && !qdiv_busy && !mul_busy))
      else $error("arithmetic unit busy in idle");

   // an accepted word starts the load step
   a_take_loads: assert property (@(posedge clock) disable iff (reset)
      (req_take && !tgt_wr) |=> (state_ff == S_LOAD))
      else $error("accepted word did not start processing");

   // a result only appears out of the update step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result raised outside the update step");

endmodule

@@ tb/tb.sv @@
// tb: self-checking bench for adaptive_frame_rate_governor, drives duration words
// and checks delay, active rate and change flag; needs afrg_pkg, afrg_req_if, afrg_rsp_if
`timescale 1ns / 100ps

module tb import afrg_pkg::*; ;

   localparam int unsigned MAX_RATE = 240;
   localparam int unsigned SETTLE   = 45;   // settle time before register writes and at the end of the run

   typedef struct packed {
      logic [DELAY_W-1:0] delay_ms;
      logic [RATE_W-1:0]  active_rate;
      logic               rate_changed;
   } update_type;

   typedef enum {PACE_FAST, PACE_STEADY, PACE_SLOW} pace_type;

   logic             clock   = 1'b0;
   logic             reset   = 1'b1;
   logic             psel    = 1'b0;
   logic             penable = 1'b0;
   logic             pwrite  = 1'b0;
   logic [ADDR_W-1:0] paddr  = '0;
   logic [CSR_W-1:0] pwdata  = '0;
   logic [CSR_W-1:0] prdata;
   logic             pready;

   afrg_req_if req_ch ();
   afrg_rsp_if rsp_ch ();

   adaptive_frame_rate_governor #(.MAX_RATE(MAX_RATE)) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #10 clock = ~clock;

   // governor mirror: registers, rate in force and q16.8 average
   logic [RATE_W-1:0] gov_target;
   logic [RATE_W-1:0] gov_min;
   logic [RATE_W-1:0] gov_rate;
   logic [AVG_W-1:0]  gov_avg;

   logic [DUR_W-1:0] pending_durations[$];
   update_type       expected_updates[$];
   int unsigned      send_pause_ff = 0;
   int unsigned      recv_stall_ff = 0;
   bit               steady_flow = 1'b0;
   int unsigned      random_items = 0;
   int unsigned      errors = 0;

   // minimum as it acts: zero behaves as one, capped at the top rate
   function automatic int unsigned min_floor();
      if (gov_min < 1) return 1;
      if (gov_min > MAX_RATE) return MAX_RATE;
      return 32'(gov_min);
   endfunction

   // target write: clamp, then restart rate and average from it
   function automatic void load_target(input int unsigned want);
      int unsigned floor_rate;
      floor_rate = min_floor();
      if (want < floor_rate) want = floor_rate;
      if (want > MAX_RATE) want = MAX_RATE;
      gov_target = RATE_W'(want);
      gov_rate   = RATE_W'(want);
      gov_avg    = AVG_W'(256000 / want);
   endfunction

   // one frame: delay from the old rate, then average and rate step
   function automatic update_type step_governor(input logic [DUR_W-1:0] dur);
      update_type      upd;
      int unsigned     rate;
      int unsigned     period;
      int unsigned     floor_rate;
      longint unsigned avg_next;
      longint unsigned avg_rate;
      rate       = 32'(gov_rate);
      floor_rate = min_floor();
      period     = 1000 / rate;
      upd.delay_ms = (period > dur) ? DELAY_W'(period - dur) : '0;
      // no adjustment unless the target leaves room above the minimum
      if (gov_target >= floor_rate + 2) begin
         avg_next = (64'(gov_avg) * 9 + (64'(dur) << 8) + 5) / 10;
         gov_avg  = avg_next[AVG_W-1:0];
         avg_rate = 64'(gov_avg) * rate;
         if (avg_rate * 10 > 11 * 256000) begin
            gov_rate = (rate - 1 < floor_rate) ? RATE_W'(floor_rate) : RATE_W'(rate - 1);
         end else if (avg_rate * 100 < 85 * 256000) begin
            gov_rate = (rate + 1 > gov_target) ? gov_target : RATE_W'(rate + 1);
         end
      end
      upd.active_rate  = gov_rate;
      upd.rate_changed = (gov_rate != rate);
      return upd;
   endfunction

   function automatic int unsigned draw_pause();
      return steady_flow ? 0 : $urandom_range(0, 14);
   endfunction

   // durations mostly around the frame period, with some noise
   function automatic logic [DUR_W-1:0] draw_duration(input int unsigned rate,
                                                      input pace_type pace);
      int unsigned per;
      int unsigned pick;
      per  = 1000 / rate;
      pick = $urandom_range(0, 99);
      if (pick < 1) return DUR_W'($urandom);
      if (pick < 3) return DUR_W'($urandom_range(0, 300));
      if (pick < 5) return '0;
      case (pace)
         PACE_FAST: return DUR_W'($urandom_range(per * 5 / 10, per * 8 / 10));
         PACE_SLOW: return DUR_W'($urandom_range(per * 12 / 10, per * 2 + 1));
         default:   return DUR_W'($urandom_range(per * 7 / 10, per * 13 / 10 + 1));
      endcase
   endfunction

   // register write, setup then access phase, only while the block is idle
   task automatic csr_write(input reg_index_type idx, input logic [RATE_W-1:0] value);
      repeat (SETTLE) @(posedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= ADDR_W'({idx, 2'b00});
      pwdata  <= CSR_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_TARGET: load_target(32'(value));
         REG_MIN:    gov_min = value;
         default:    ;
      endcase
   endtask

   task automatic wait_drain();
      while (pending_durations.size() != 0 || req_ch.valid || expected_updates.size() != 0)
         @(negedge clock);
   endtask

   // random segment, pace drawn anew every 25 words
   task automatic run_items(input int unsigned count);
      pace_type pace;
      pace = PACE_STEADY;
      @(negedge clock);
      steady_flow = ($urandom_range(0, 3) == 0);
      for (int unsigned i = 0; i < count; i++) begin
         if (i % 25 == 0) pace = pace_type'($urandom_range(0, 2));
         pending_durations.push_back(draw_duration(32'(gov_target), pace));
      end
      random_items += count;
      wait_drain();
   endtask

   // driver: one duration word per handshake, mirror stepped on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid          <= 1'b0;
         req_ch.frame_duration <= '0;
         send_pause_ff         <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            expected_updates.push_back(step_governor(req_ch.frame_duration));
         if (!req_ch.valid || req_ch.ready) begin
            if (send_pause_ff != 0) begin
               req_ch.valid  <= 1'b0;
               send_pause_ff <= send_pause_ff - 1;
            end else if (pending_durations.size() != 0) begin
               req_ch.valid          <= 1'b1;
               req_ch.frame_duration <= pending_durations.pop_front();
               send_pause_ff         <= draw_pause();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each result word with the oldest expectation
   always @(posedge clock) begin : monitor
      update_type  want;
      int unsigned hold;
      if (reset) begin
         rsp_ch.ready  <= 1'b0;
         recv_stall_ff <= 0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         if (expected_updates.size() == 0) begin
            errors++;
            $display("%0t: unexpected result delay %0d rate %0d changed %0d", $time,
                     rsp_ch.delay_ms, rsp_ch.active_rate, rsp_ch.rate_changed);
         end else begin
            want = expected_updates.pop_front();
            if (rsp_ch.delay_ms !== want.delay_ms) begin
               errors++;
               $display("%0t: delay_ms expected %0d actual %0d", $time,
                        want.delay_ms, rsp_ch.delay_ms);
            end
            if (rsp_ch.active_rate !== want.active_rate) begin
               errors++;
               $display("%0t: active_rate expected %0d actual %0d", $time,
                        want.active_rate, rsp_ch.active_rate);
            end
            if (rsp_ch.rate_changed !== want.rate_changed) begin
               errors++;
               $display("%0t: rate_changed expected %0d actual %0d", $time,
                        want.rate_changed, rsp_ch.rate_changed);
            end
         end
         hold = draw_pause();
         recv_stall_ff <= hold;
         rsp_ch.ready  <= (hold == 0);
      end else if (recv_stall_ff != 0) begin
         recv_stall_ff <= recv_stall_ff - 1;
         rsp_ch.ready  <= (recv_stall_ff == 1);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // stimulus and end of run
   initial begin
      int unsigned min_pick;
      int unsigned target_pick;
      gov_min = RATE_W'(RST_MIN);
      load_target(RST_TARGET);
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset settings: around the 16 ms period, extremes and bit patterns
      @(negedge clock);
      pending_durations = {16'd16, 16'd15, 16'd17, 16'd1, 16'd999, 16'd1000, 16'd0,
                           16'd0, 16'hFFFF, 16'hAAAA, 16'h5555, 16'd0, 16'd0};
      wait_drain();

      // target above the top rate is capped, minimum at its lowest
      csr_write(REG_MIN, 8'd1);
      csr_write(REG_TARGET, 8'd255);
      @(negedge clock);
      pending_durations = {16'd4, 16'd3, 16'd5, 16'd0};
      wait_drain();
      run_items(150);

      // zero minimum acts as one, zero target lifted to it, no room to adjust
      csr_write(REG_MIN, 8'd0);
      csr_write(REG_TARGET, 8'd0);
      @(negedge clock);
      pending_durations = {16'd0, 16'd999, 16'd1000, 16'd1001};
      wait_drain();
      run_items(30);

      // smallest target that still allows adjustment
      csr_write(REG_TARGET, 8'd3);
      run_items(100);

      // minimum above the top rate, target pulled up to it
      csr_write(REG_MIN, 8'd255);
      csr_write(REG_TARGET, 8'd100);
      run_items(30);

      // rate driven low, then minimum raised above it: next slow step lifts it
      csr_write(REG_MIN, 8'd20);
      csr_write(REG_TARGET, 8'd200);
      @(negedge clock);
      for (int unsigned i = 0; i < 150; i++)
         pending_durations.push_back(DUR_W'($urandom_range(150, 400)));
      random_items += 150;
      wait_drain();
      csr_write(REG_MIN, 8'd100);
      run_items(120);

      // random settings, written in either order
      while (random_items < 1600) begin
         case ($urandom_range(0, 19))
            0, 1:    min_pick = 0;
            2:       min_pick = 255;
            default: min_pick = $urandom_range(1, 120);
         endcase
         case ($urandom_range(0, 19))
            0:       target_pick = 0;
            1:       target_pick = 255;
            default: target_pick = $urandom_range(1, 240);
         endcase
         if ($urandom_range(0, 3) == 0) begin
            csr_write(REG_TARGET, RATE_W'(target_pick));
            csr_write(REG_MIN, RATE_W'(min_pick));
         end else begin
            csr_write(REG_MIN, RATE_W'(min_pick));
            csr_write(REG_TARGET, RATE_W'(target_pick));
         end
         run_items($urandom_range(80, 200));
      end

      wait_drain();
      repeat (SETTLE) @(posedge clock);
      if (errors == 0)
         $display("adaptive_frame_rate_governor: match");
      else
         $display("adaptive_frame_rate_governor: mismatch");
      $finish;
   end

   // run limit, far above the slowest correct run
   initial begin
      #20ms;
      $display("adaptive_frame_rate_governor: mismatch");
      $finish;
   end

endmodule
